/* rtl/core/cpe_pkg.sv */
package cpe_pkg;

	localparam int PARTICLE_COUNT = 64;
	localparam int IDX_W = $clog2(PARTICLE_COUNT);
	localparam int VAL_W = 32;
	localparam int CHG_W = 16;
	localparam int MASS_W = 16;
	localparam int DT_W = 16;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIFF_W = VAL_W + 1;
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int WIDE_W = 64;
	localparam int SUM_W = WIDE_W + 2;
	localparam int D2_W = 50;
	localparam int KQ_W = 46;
	localparam int MAG_W = 62;
	localparam int R_W = 32;
	localparam int U_W = 31;
	localparam int COMP_W = 63;
	localparam int CNT_W = 6;
	localparam int DIV_STEPS = 64;
	localparam int SQRT_STEPS = 32;

	localparam logic [CFG_W-1:0] FORCE_CONSTANT_RST = 32'd65536;
	localparam logic [DT_W-1:0] TIME_STEP_RST = 16'd655;
	localparam logic [DT_W-1:0] SOFTENING_RST = 16'd1;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_PAIR = 2'd1,
		OP_INTEGRATE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FORCE_CONSTANT = 2'd0,
		CFG_TIME_STEP = 2'd1,
		CFG_SOFTENING = 2'd2
	} cfg_idx_t;

	typedef logic [2:0][VAL_W-1:0] vec3_t;

	// request to the shared divide / square root unit
	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} dsu_req_t;

	function automatic logic [DIFF_W-1:0] mag33(input logic [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? DIFF_W'(-v) : v;
	endfunction

	function automatic logic [CHG_W:0] mag17(input logic [CHG_W-1:0] q);
		logic [CHG_W:0] e;
		e = {q[CHG_W-1], q};
		return e[CHG_W] ? (CHG_W+1)'(-e) : e;
	endfunction

	// add a signed magnitude to base and clamp to the value range
	function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] base,
			input logic [WIDE_W-1:0] m, input logic neg);
		logic [SUM_W-1:0] b_ext;
		logic [SUM_W-1:0] m_ext;
		logic [SUM_W-1:0] s;
		logic [SUM_W-VAL_W:0] top;
		b_ext = {{(SUM_W-VAL_W){base[VAL_W-1]}}, base};
		m_ext = {2'b00, m};
		s = neg ? (b_ext - m_ext) : (b_ext + m_ext);
		top = s[SUM_W-1:VAL_W-1];
		if (s[SUM_W-1] && (top != '1))
			return {1'b1, {(VAL_W-1){1'b0}}};
		else if (!s[SUM_W-1] && (top != '0))
			return {1'b0, {(VAL_W-1){1'b1}}};
		else
			return s[VAL_W-1:0];
	endfunction

endpackage

/* rtl/core/cpe_ram.sv */
module cpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/cpe_mul.sv */
module cpe_mul import cpe_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] p
);

	// register the product
	always_ff @(posedge clk) begin
		p <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

/* rtl/core/cpe_dsu.sv */
module cpe_dsu import cpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dsu_req_t          req,
	input  logic [WIDE_W-1:0] num,
	input  logic [WIDE_W-1:0] den,
	output logic              done,
	output logic [WIDE_W-1:0] result
);

	logic              busy_q;
	logic              done_q;
	logic              mode_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] res_q;
	logic [WIDE_W-1:0] aux_q;
	logic [WIDE_W-1:0] den_q;

	logic [WIDE_W:0]   rem_n;
	logic [WIDE_W-1:0] trial;
	logic              ge;
	logic [WIDE_W-1:0] acc_d;
	logic [WIDE_W-1:0] res_d;
	logic [WIDE_W-1:0] aux_d;

	// one restoring step: quotient bit or root bit
	always_comb begin
		rem_n = {acc_q, aux_q[WIDE_W-1]};
		trial = res_q + aux_q;
		if (mode_q) begin
			ge = acc_q >= trial;
			acc_d = ge ? (acc_q - trial) : acc_q;
			res_d = ge ? ((res_q >> 1) + aux_q) : (res_q >> 1);
			aux_d = aux_q >> 2;
		end else begin
			ge = rem_n >= {1'b0, den_q};
			acc_d = ge ? WIDE_W'(rem_n - {1'b0, den_q}) : rem_n[WIDE_W-1:0];
			res_d = {res_q[WIDE_W-2:0], ge};
			aux_d = aux_q << 1;
		end
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					mode_q <= req.sqrt_mode;
					den_q <= den;
					res_q <= '0;
					if (req.sqrt_mode) begin
						acc_q <= num;
						aux_q <= {2'b01, {(WIDE_W-2){1'b0}}};
						cnt_q <= CNT_W'(SQRT_STEPS - 1);
					end else begin
						acc_q <= '0;
						aux_q <= num;
						cnt_q <= CNT_W'(DIV_STEPS - 1);
					end
				end
			end else begin
				acc_q <= acc_d;
				res_q <= res_d;
				aux_q <= aux_d;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

/* rtl/core/pairwise_coulomb_euler_step.sv */
// A load writes the table and an unused code returns to idle. Pair uses one root of 32 steps
// and four divisions of 64 steps each in the divide/root unit, and ends early when the squared
// distance or its root is zero; integrate uses one division per axis unless the mass is zero.
// An integrate result is strobed on done in the cycle that busy falls; here the receiver
// cannot stall. Throughput: one item at a time, busy high until it is done.
// Reset clears control and presets the configuration; the table is undefined until loaded.
module pairwise_coulomb_euler_step import cpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [1:0]           operation,
	input  logic [IDX_W-1:0]     index_a,
	input  logic [IDX_W-1:0]     index_b,
	input  logic signed [VAL_W-1:0] pos_x,
	input  logic signed [VAL_W-1:0] pos_y,
	input  logic signed [VAL_W-1:0] pos_z,
	input  logic signed [CHG_W-1:0] charge,
	input  logic [MASS_W-1:0]    mass,
	output logic [IDX_W-1:0]     particle_index,
	output logic signed [VAL_W-1:0] new_pos_x,
	output logic signed [VAL_W-1:0] new_pos_y,
	output logic signed [VAL_W-1:0] new_pos_z,
	output logic signed [VAL_W-1:0] new_vel_x,
	output logic signed [VAL_W-1:0] new_vel_y,
	output logic signed [VAL_W-1:0] new_vel_z
);

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD,
		P_RDA, P_RDB, P_DIFF, P_SQ, P_ACC, P_CHK, P_QQ, P_KQ, P_SQRT, P_MAG,
		P_U, P_CHI, P_CLO, P_CSUM,
		F_RDA, F_WA, F_RDB, F_WB,
		I_RD, I_CAP, I_AX, I_DVS, I_DVW, I_VDT, I_POS, I_WR
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] force_constant_q;
	logic [DT_W-1:0]  time_step_q;
	logic [DT_W-1:0]  softening_q;

	logic [IDX_W-1:0]  ia_q;
	logic [IDX_W-1:0]  ib_q;
	vec3_t             in_pos_q;
	logic [CHG_W-1:0]  in_charge_q;
	logic [MASS_W-1:0] in_mass_q;

	vec3_t             pa_q;
	logic [CHG_W-1:0]  qa_q;
	logic [CHG_W-1:0]  qb_q;
	logic [DIFF_W-1:0] ad_q [3];
	logic [2:0]        dneg_q;
	logic [1:0]        ax_q;
	logic [D2_W-1:0]   d2_q;
	logic [R_W-1:0]    r_q;
	logic [KQ_W-1:0]   kq_q;
	logic [MAG_W-1:0]  mag_q;
	logic [U_W-1:0]    u_q;
	logic [COMP_W-1:0] chi_q;
	logic [COMP_W-1:0] c_q [3];

	vec3_t             p_q;
	vec3_t             v_q;
	vec3_t             f_q;
	logic [MASS_W-1:0] m_q;

	logic              done_q;
	logic [IDX_W-1:0]  out_idx_q;
	vec3_t             out_pos_q;
	vec3_t             out_vel_q;

	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  waddr;
	logic              pos_we;
	logic              vel_we;
	logic              frc_we;
	logic              cm_we;
	vec3_t             pos_wd;
	vec3_t             vel_wd;
	vec3_t             frc_wd;
	vec3_t             pos_rd;
	vec3_t             vel_rd;
	vec3_t             frc_rd;
	logic [CHG_W+MASS_W-1:0] cm_rd;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;

	dsu_req_t          dsu_req;
	logic [WIDE_W-1:0] dsu_num;
	logic [WIDE_W-1:0] dsu_den;
	logic              dsu_done;
	logic [WIDE_W-1:0] dsu_res;

	logic              qneg;
	logic [1:0]        ax_nxt;
	logic [DIFF_W-1:0] diff [3];

	assign qneg = qa_q[CHG_W-1] ^ qb_q[CHG_W-1];
	assign ax_nxt = ax_q + 2'd1;

	// separation of the two particles per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {pa_q[i][VAL_W-1], pa_q[i]} - {pos_rd[i][VAL_W-1], pos_rd[i]};
		end
	end

	// table storage
	cpe_ram #(.WIDTH(3 * VAL_W), .DEPTH(PARTICLE_COUNT)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(waddr), .wdata(pos_wd),
		.raddr(raddr), .rdata(pos_rd)
	);
	cpe_ram #(.WIDTH(3 * VAL_W), .DEPTH(PARTICLE_COUNT)) u_vel_ram (
		.clk(clk), .we(vel_we), .waddr(waddr), .wdata(vel_wd),
		.raddr(raddr), .rdata(vel_rd)
	);
	cpe_ram #(.WIDTH(3 * VAL_W), .DEPTH(PARTICLE_COUNT)) u_frc_ram (
		.clk(clk), .we(frc_we), .waddr(waddr), .wdata(frc_wd),
		.raddr(raddr), .rdata(frc_rd)
	);
	cpe_ram #(.WIDTH(CHG_W + MASS_W), .DEPTH(PARTICLE_COUNT)) u_cm_ram (
		.clk(clk), .we(cm_we), .waddr(waddr), .wdata({in_charge_q, in_mass_q}),
		.raddr(raddr), .rdata(cm_rd)
	);

	cpe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	cpe_dsu u_dsu (
		.clk(clk), .arst_n(arst_n), .req(dsu_req), .num(dsu_num), .den(dsu_den),
		.done(dsu_done), .result(dsu_res)
	);

	// table addresses and writes
	always_comb begin
		raddr = ia_q;
		waddr = ia_q;
		pos_we = 1'b0;
		vel_we = 1'b0;
		frc_we = 1'b0;
		cm_we = 1'b0;
		pos_wd = p_q;
		vel_wd = v_q;
		frc_wd = '0;
		unique case (state_q)
			P_RDB, F_RDB: raddr = ib_q;
			S_LOAD: begin
				pos_we = 1'b1;
				vel_we = 1'b1;
				frc_we = 1'b1;
				cm_we = 1'b1;
				pos_wd = in_pos_q;
				vel_wd = '0;
			end
			F_WA: begin
				frc_we = 1'b1;
				for (int i = 0; i < 3; i++) begin
					frc_wd[i] = sat_add(frc_rd[i], WIDE_W'(c_q[i]), qneg ^ dneg_q[i]);
				end
			end
			F_WB: begin
				waddr = ib_q;
				frc_we = 1'b1;
				for (int i = 0; i < 3; i++) begin
					frc_wd[i] = sat_add(frc_rd[i], WIDE_W'(c_q[i]), !(qneg ^ dneg_q[i]));
				end
			end
			I_WR: begin
				pos_we = 1'b1;
				vel_we = 1'b1;
				frc_we = 1'b1;
			end
			default: ;
		endcase
	end

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			P_SQ: begin
				mul_a = ad_q[ax_q];
				mul_b = ad_q[ax_q];
			end
			P_CHK: begin
				mul_a = MUL_W'(mag17(qa_q));
				mul_b = MUL_W'(mag17(qb_q));
			end
			P_QQ: begin
				mul_a = MUL_W'(force_constant_q);
				mul_b = MUL_W'(mul_p[30:0]);
			end
			P_CHI: begin
				mul_a = MUL_W'(mag_q[MAG_W-1:30]);
				mul_b = MUL_W'(u_q);
			end
			P_CLO: begin
				mul_a = MUL_W'(mag_q[29:0]);
				mul_b = MUL_W'(u_q);
			end
			I_AX: begin
				mul_a = mag33({f_q[ax_q][VAL_W-1], f_q[ax_q]});
				mul_b = MUL_W'(time_step_q);
			end
			I_VDT: begin
				mul_a = mag33({v_q[ax_q][VAL_W-1], v_q[ax_q]});
				mul_b = MUL_W'(time_step_q);
			end
			default: ;
		endcase
	end

	// divide / root requests
	always_comb begin
		dsu_req = '0;
		dsu_num = '0;
		dsu_den = '0;
		unique case (state_q)
			P_CHK: begin
				dsu_req.start = (d2_q != '0);
				dsu_req.sqrt_mode = 1'b1;
				dsu_num = {d2_q, 14'd0};
			end
			P_SQRT: begin
				dsu_req.start = dsu_done && (dsu_res != '0);
				dsu_num = WIDE_W'({kq_q, 16'd0});
				dsu_den = WIDE_W'(d2_q);
			end
			P_MAG: begin
				dsu_req.start = dsu_done;
				dsu_num = WIDE_W'({ad_q[0], 29'd0});
				dsu_den = WIDE_W'(r_q);
			end
			P_CSUM: begin
				dsu_req.start = (ax_q != 2'd2);
				dsu_num = WIDE_W'({ad_q[ax_nxt], 29'd0});
				dsu_den = WIDE_W'(r_q);
			end
			I_DVS: begin
				dsu_req.start = 1'b1;
				dsu_num = WIDE_W'(mul_p[48:0]);
				dsu_den = WIDE_W'({m_q, 8'd0});
			end
			default: ;
		endcase
	end

	// sequencer, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			force_constant_q <= FORCE_CONSTANT_RST;
			time_step_q <= TIME_STEP_RST;
			softening_q <= SOFTENING_RST;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_FORCE_CONSTANT: force_constant_q <= cfg_data;
					CFG_TIME_STEP: time_step_q <= cfg_data[DT_W-1:0];
					CFG_SOFTENING: softening_q <= cfg_data[DT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ia_q <= index_a;
						ib_q <= index_b;
						in_pos_q <= {pos_z, pos_y, pos_x};
						in_charge_q <= charge;
						in_mass_q <= mass;
						unique case (op_t'(operation))
							OP_LOAD: state_q <= S_LOAD;
							OP_PAIR: state_q <= P_RDA;
							OP_INTEGRATE: state_q <= I_RD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: state_q <= S_IDLE;
				P_RDA: state_q <= P_RDB;
				P_RDB: begin
					pa_q <= pos_rd;
					qa_q <= cm_rd[CHG_W+MASS_W-1:MASS_W];
					state_q <= P_DIFF;
				end
				P_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						dneg_q[i] <= diff[i][DIFF_W-1];
						ad_q[i] <= mag33(diff[i]);
					end
					qb_q <= cm_rd[CHG_W+MASS_W-1:MASS_W];
					d2_q <= D2_W'(softening_q);
					ax_q <= '0;
					state_q <= P_SQ;
				end
				P_SQ: state_q <= P_ACC;
				P_ACC: begin
					d2_q <= d2_q + D2_W'(mul_p[PROD_W-1:16]);
					ax_q <= ax_nxt;
					state_q <= (ax_q == 2'd2) ? P_CHK : P_SQ;
				end
				P_CHK: state_q <= (d2_q == '0) ? S_IDLE : P_QQ;
				P_QQ: state_q <= P_KQ;
				P_KQ: begin
					kq_q <= mul_p[KQ_W+15:16];
					state_q <= P_SQRT;
				end
				P_SQRT: begin
					if (dsu_done) begin
						r_q <= dsu_res[R_W-1:0];
						state_q <= (dsu_res == '0) ? S_IDLE : P_MAG;
					end
				end
				P_MAG: begin
					if (dsu_done) begin
						mag_q <= dsu_res[MAG_W-1:0];
						ax_q <= '0;
						state_q <= P_U;
					end
				end
				P_U: begin
					if (dsu_done) begin
						// clamp the unit-vector component at one
						if (dsu_res > WIDE_W'(64'd1 << 30)) begin
							u_q <= U_W'(64'd1 << 30);
						end else begin
							u_q <= dsu_res[U_W-1:0];
						end
						state_q <= P_CHI;
					end
				end
				P_CHI: state_q <= P_CLO;
				P_CLO: begin
					chi_q <= mul_p[COMP_W-1:0];
					state_q <= P_CSUM;
				end
				P_CSUM: begin
					c_q[ax_q] <= chi_q + COMP_W'(mul_p[60:30]);
					ax_q <= ax_nxt;
					state_q <= (ax_q == 2'd2) ? F_RDA : P_U;
				end
				F_RDA: state_q <= F_WA;
				F_WA: state_q <= F_RDB;
				F_RDB: state_q <= F_WB;
				F_WB: state_q <= S_IDLE;
				I_RD: state_q <= I_CAP;
				I_CAP: begin
					p_q <= pos_rd;
					v_q <= vel_rd;
					f_q <= frc_rd;
					m_q <= cm_rd[MASS_W-1:0];
					ax_q <= '0;
					state_q <= I_AX;
				end
				I_AX: state_q <= (m_q == '0) ? I_VDT : I_DVS;
				I_DVS: state_q <= I_DVW;
				I_DVW: begin
					if (dsu_done) begin
						v_q[ax_q] <= sat_add(v_q[ax_q], dsu_res, f_q[ax_q][VAL_W-1]);
						state_q <= I_VDT;
					end
				end
				I_VDT: state_q <= I_POS;
				I_POS: begin
					p_q[ax_q] <= sat_add(p_q[ax_q], WIDE_W'(mul_p[48:16]), v_q[ax_q][VAL_W-1]);
					ax_q <= ax_nxt;
					state_q <= (ax_q == 2'd2) ? I_WR : I_AX;
				end
				I_WR: begin
					done_q <= 1'b1;
					out_idx_q <= ia_q;
					out_pos_q <= p_q;
					out_vel_q <= v_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign particle_index = out_idx_q;
	assign new_pos_x = out_pos_q[0];
	assign new_pos_y = out_pos_q[1];
	assign new_pos_z = out_pos_q[2];
	assign new_vel_x = out_vel_q[0];
	assign new_vel_y = out_vel_q[1];
	assign new_vel_z = out_vel_q[2];

endmodule

/* sim/pairwise_coulomb_euler_step_tb.sv */
module pairwise_coulomb_euler_step_tb import cpe_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT = 3000000;
	localparam int ITEMS_PER_PHASE = 250;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] px, py, pz, vx, vy, vz;
	} motion_t;

	typedef struct {
		op_t op;
		logic [IDX_W-1:0] ia, ib;
		logic [VAL_W-1:0] px, py, pz;
		logic [CHG_W-1:0] q;
		logic [MASS_W-1:0] m;
		bit has_exp;
		motion_t exp_res;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic [1:0] operation = '0;
	logic [IDX_W-1:0] index_a = '0, index_b = '0;
	logic signed [VAL_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [CHG_W-1:0] charge = '0;
	logic [MASS_W-1:0] mass = '0;
	logic [IDX_W-1:0] particle_index;
	logic signed [VAL_W-1:0] new_pos_x, new_pos_y, new_pos_z;
	logic signed [VAL_W-1:0] new_vel_x, new_vel_y, new_vel_z;

	// predictor state
	longint unsigned k_coul = 64'd65536, dt_frac = 64'd655, soft_d2 = 64'd1;
	longint pos_s[PARTICLE_COUNT][3], vel_s[PARTICLE_COUNT][3], frc_s[PARTICLE_COUNT][3];
	longint chg_s[PARTICLE_COUNT];
	longint unsigned mass_s[PARTICLE_COUNT];
	bit loaded[PARTICLE_COUNT];
	int loaded_list[$];

	motion_t pending_motion[$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	cmd_t plan[$];

	pairwise_coulomb_euler_step dut (.*);

	always #1 clk = ~clk;

	// abort on a hung block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("pairwise_coulomb_euler_step_tb: done, errors");
			$finish;
		end
	end

	function automatic longint clamp(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	function automatic longint unsigned absv(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint signed_mag(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned root_u64(longint unsigned v);
		longint unsigned res, bv;
		res = 0;
		bv = 64'h4000_0000_0000_0000;
		while (bv > v) bv >>= 2;
		while (bv != 0) begin
			if (v >= res + bv) begin
				v -= res + bv;
				res = (res >> 1) + bv;
			end else begin
				res >>= 1;
			end
			bv >>= 2;
		end
		return res;
	endfunction

	// accumulate the softened Coulomb force of b on a, opposite on b
	function automatic void apply_pair(int a, int b);
		longint dv[3];
		longint unsigned ad[3];
		longint unsigned d2, r, kq, fmag, u, cm;
		longint qq, c;
		bit qneg;
		d2 = soft_d2;
		for (int i = 0; i < 3; i++) begin
			dv[i] = pos_s[a][i] - pos_s[b][i];
			ad[i] = absv(dv[i]);
			d2 += (ad[i] * ad[i]) >> 16;
		end
		if (d2 == 0) return;
		r = root_u64(d2 << 14);
		if (r == 0) return;
		qq = chg_s[a] * chg_s[b];
		qneg = qq < 0;
		kq = (k_coul * absv(qq)) >> 16;
		fmag = (kq << 16) / d2;
		for (int i = 0; i < 3; i++) begin
			u = (ad[i] << 29) / r;
			if (u > (64'd1 << 30)) u = 64'd1 << 30;
			cm = (fmag >> 30) * u + (((fmag & ((64'd1 << 30) - 1)) * u) >> 30);
			c = signed_mag(cm, qneg != (dv[i] < 0));
			frc_s[a][i] = clamp(frc_s[a][i] + c);
			frc_s[b][i] = clamp(frc_s[b][i] - c);
		end
	endfunction

	// semi-implicit Euler step of one particle
	function automatic motion_t advance_particle(int a);
		motion_t res;
		longint unsigned dvel;
		for (int i = 0; i < 3; i++) begin
			if (mass_s[a] != 0) begin
				dvel = (absv(frc_s[a][i]) * dt_frac) / (mass_s[a] << 8);
				vel_s[a][i] = clamp(vel_s[a][i] + signed_mag(dvel, frc_s[a][i] < 0));
			end
			pos_s[a][i] = clamp(pos_s[a][i] +
				signed_mag((absv(vel_s[a][i]) * dt_frac) >> 16, vel_s[a][i] < 0));
			frc_s[a][i] = 0;
		end
		res.idx = IDX_W'(a);
		res.px = 32'(pos_s[a][0]); res.py = 32'(pos_s[a][1]); res.pz = 32'(pos_s[a][2]);
		res.vx = 32'(vel_s[a][0]); res.vy = 32'(vel_s[a][1]); res.vz = 32'(vel_s[a][2]);
		return res;
	endfunction

	// update the table and return whether an integrate result follows
	function automatic bit predict_item(cmd_t c, output motion_t res);
		int a;
		a = c.ia;
		res = '0;
		case (c.op)
			OP_LOAD: begin
				pos_s[a][0] = longint'($signed(c.px));
				pos_s[a][1] = longint'($signed(c.py));
				pos_s[a][2] = longint'($signed(c.pz));
				chg_s[a] = longint'($signed(c.q));
				mass_s[a] = 64'(c.m);
				for (int i = 0; i < 3; i++) begin
					vel_s[a][i] = 0;
					frc_s[a][i] = 0;
				end
				if (!loaded[a]) begin
					loaded[a] = 1'b1;
					loaded_list.push_back(a);
				end
				return 1'b0;
			end
			OP_PAIR: begin
				apply_pair(a, c.ib);
				return 1'b0;
			end
			OP_INTEGRATE: begin
				res = advance_particle(a);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic cmd_t mk(op_t op, int ia, int ib, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [15:0] q, logic [15:0] m);
		cmd_t c;
		c.op = op; c.ia = IDX_W'(ia); c.ib = IDX_W'(ib);
		c.px = px; c.py = py; c.pz = pz; c.q = q; c.m = m;
		c.has_exp = 1'b0;
		c.exp_res = '0;
		return c;
	endfunction

	function automatic cmd_t mk_exp(int ia, motion_t e);
		cmd_t c;
		c = mk(OP_INTEGRATE, ia, 0, 0, 0, 0, 0, 0);
		c.has_exp = 1'b1;
		c.exp_res = e;
		return c;
	endfunction

	// drive one item, hold until accepted, then queue its result
	task automatic send_item(cmd_t c);
		motion_t res;
		start <= 1'b1;
		operation <= c.op;
		index_a <= c.ia; index_b <= c.ib;
		pos_x <= c.px; pos_y <= c.py; pos_z <= c.pz;
		charge <= c.q; mass <= c.m;
		do @(posedge clk); while (busy);
		if (predict_item(c, res))
			pending_motion.push_back(c.has_exp ? c.exp_res : res);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// hold off until all results are in and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_motion.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_FORCE_CONSTANT: k_coul = 64'(val);
			CFG_TIME_STEP: dt_frac = 64'(val[DT_W-1:0]);
			default: soft_d2 = 64'(val[DT_W-1:0]);
		endcase
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		endcase
	endfunction

	function automatic cmd_t rand_load(int ia);
		return mk(OP_LOAD, ia, $urandom_range(63), rand_pos(), rand_pos(), rand_pos(),
			16'($urandom), ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)));
	endfunction

	function automatic cmd_t rand_item();
		int sel, ia, ib;
		sel = $urandom_range(99);
		ia = $urandom_range(63);
		if (sel < 5)
			return mk(OP_NONE, ia, $urandom_range(63), $urandom, $urandom, $urandom,
				16'($urandom), 16'($urandom));
		if (sel < 25 || loaded_list.size() == 0 || !loaded[ia])
			return rand_load(ia);
		if (sel < 65) begin
			ib = loaded_list[$urandom_range(loaded_list.size() - 1)];
			if ($urandom_range(15) == 0) ib = ia;
			return mk(OP_PAIR, ia, ib, $urandom, $urandom, $urandom,
				16'($urandom), 16'($urandom));
		end
		return mk(OP_INTEGRATE, ia, $urandom_range(63), $urandom, $urandom, $urandom,
			16'($urandom), 16'($urandom));
	endfunction

	// compare one result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			motion_t want, got;
			logic [31:0] w[7], g[7];
			string nm[7];
			got = {particle_index, new_pos_x, new_pos_y, new_pos_z,
				new_vel_x, new_vel_y, new_vel_z};
			if (pending_motion.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				want = pending_motion.pop_front();
				nm = '{"particle_index", "new_pos_x", "new_pos_y", "new_pos_z",
					"new_vel_x", "new_vel_y", "new_vel_z"};
				w = '{32'(want.idx), want.px, want.py, want.pz, want.vx, want.vy, want.vz};
				g = '{32'(got.idx), got.px, got.py, got.pz, got.vx, got.vy, got.vz};
				for (int i = 0; i < 7; i++)
					if (w[i] !== g[i]) begin
						$display("%0t: %s expected %h actual %h", $time, nm[i], w[i], g[i]);
						errors++;
					end
			end
		end
	end

	initial begin
		logic [31:0] same_pt;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset settings
		plan.push_back(mk(OP_LOAD, 0, 0, 0, 0, 0, 16'h0100, 16'h0100));
		plan.push_back(mk_exp(0, '{0, 0, 0, 0, 0, 0, 0}));
		plan.push_back(mk(OP_LOAD, 1, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 16'h8000, 16'hffff));
		plan.push_back(mk_exp(1, '{1, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0}));
		plan.push_back(mk(OP_LOAD, 2, 0, 32'h0001_0000, 0, 0, 16'h7fff, 16'h0001));
		plan.push_back(mk(OP_PAIR, 0, 2, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_PAIR, 2, 1, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_PAIR, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_INTEGRATE, 2, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_INTEGRATE, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_LOAD, 3, 0, 32'h0002_0000, 0, 0, 16'h0064, 16'h0000));
		plan.push_back(mk(OP_PAIR, 3, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_INTEGRATE, 3, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_NONE, 63, 63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			16'hffff, 16'hffff));
		plan.push_back(mk(OP_LOAD, 63, 63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			16'h0001, 16'h0100));
		plan.push_back(mk(OP_PAIR, 63, 1, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_INTEGRATE, 63, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_INTEGRATE, 1, 0, 0, 0, 0, 0, 0));
		foreach (plan[i]) send_item(plan[i]);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				1: begin
					write_reg(CFG_FORCE_CONSTANT, 32'hffff_ffff);
					write_reg(CFG_TIME_STEP, 32'd65535);
					write_reg(CFG_SOFTENING, 32'd0);
				end
				2: begin
					write_reg(CFG_FORCE_CONSTANT, 32'd0);
					write_reg(CFG_TIME_STEP, 32'd0);
					write_reg(CFG_SOFTENING, 32'd65535);
				end
				3: begin
					write_reg(CFG_FORCE_CONSTANT, $urandom_range(0, 32'h0010_0000));
					write_reg(CFG_TIME_STEP, $urandom_range(65535));
					write_reg(CFG_SOFTENING, $urandom_range(1, 65535));
				end
				default: ;
			endcase
			idle_pct = (ph == 0) ? 11 : (ph == 1) ? 73 : 0;

			// two particles at one point, then their pair and step
			same_pt = rand_pos();
			send_item(mk(OP_LOAD, 60, 0, same_pt, same_pt, same_pt, 16'h0200, 16'h0100));
			send_item(mk(OP_LOAD, 61, 0, same_pt, same_pt, same_pt, 16'hfe00, 16'h0100));
			send_item(mk(OP_PAIR, 60, 61, 0, 0, 0, 0, 0));
			send_item(mk(OP_INTEGRATE, 60, 0, 0, 0, 0, 0, 0));

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_item(rand_item());
				if ($urandom_range(99) == 0) drain();
			end
		end

		// wait out the tail
		start <= 1'b0;
		while (pending_motion.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending_motion.size() == 0)
			$display("pairwise_coulomb_euler_step_tb: done, clean");
		else
			$display("pairwise_coulomb_euler_step_tb: done, errors");
		$finish;
	end

endmodule
